>>> hw/rtl/efl_pkg.sv
// Shared constants, codes and types of the entity identifier allocator.
package efl_pkg;

    localparam int unsigned MAX_ENTITIES = 4096;
    localparam int unsigned ID_W         = 12;
    localparam int unsigned ADDR_W       = $clog2(MAX_ENTITIES);
    localparam int unsigned CNT_W        = $clog2(MAX_ENTITIES + 1);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTITIES);

    typedef enum logic [2:0] {
        MODE_ALLOC   = 3'd0,
        MODE_CLAIM   = 3'd1,
        MODE_RELEASE = 3'd2,
        MODE_EXISTS  = 3'd3,
        MODE_FIRST   = 3'd4,
        MODE_NEXT    = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_FULL    = 2'd1,
        STAT_NONE    = 2'd2,
        STAT_INVALID = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_POP,
        S_CAND,
        S_SRD,
        S_SCMP,
        S_MOVE_WR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic start;
        logic step;
    } search_ctl_t;

    typedef struct packed {
        logic match;
        logic last;
    } search_sts_t;

endpackage

>>> hw/rtl/entity_id_free_list_allocator.sv
// Top level of the entity identifier allocator: sequencer, counters and output register.
//
// Each input word on the s_ channel carries one request: the mode in s_tuser and the
// identifier in s_tdata. Each request gives exactly one output word on the m_ channel:
// the identifier in m_tdata[11:0], the exists flag in m_tdata[12], the status in m_tuser.
// The block takes one request at a time; s_tready is low from acceptance until the
// result is moved into the output register.
// Release, exists of an identifier at or above the high-water mark, and allocate from
// the high-water count go from S_DECODE straight to S_DONE; allocate from the free
// stack goes through S_POP first. Claim and exists read the free stack through one
// registered port and compare each entry in the shared search unit, in states S_SRD
// and S_SCMP for each entry; claim then moves the top entry into its slot in S_MOVE_WR.
// First and next repeat that search for each candidate identifier, set up in S_CAND.
// The next request can be accepted in the cycle after a result is loaded; the block
// takes no new request while the last one is still in progress.
// Reset empties the free stack and clears the high-water count; the stack memory needs
// no clearing pass. When the receiver stalls, the result waits in the output register
// and a new request may be accepted, but its result waits until the register is free.
module entity_id_free_list_allocator
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] entity_id, [15:12] zero
    input  logic [2:0]  s_tuser,   // [2:0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [11:0] result_id, [12] present, [15:13] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    efl_pkg::state_t state_reg;
    efl_pkg::state_t state_next;

    logic [efl_pkg::CNT_W-1:0]  high_mark_reg;
    logic [efl_pkg::CNT_W-1:0]  high_mark_next;
    logic [efl_pkg::CNT_W-1:0]  free_count_reg;
    logic [efl_pkg::CNT_W-1:0]  free_count_next;
    logic                       m_valid_reg;
    logic                       m_valid_next;

    logic [2:0]                 mode_reg;
    logic [2:0]                 mode_next;
    logic [efl_pkg::ID_W-1:0]   id_reg;
    logic [efl_pkg::ID_W-1:0]   id_next;
    logic [efl_pkg::CNT_W-1:0]  cand_reg;
    logic [efl_pkg::CNT_W-1:0]  cand_next;
    logic [efl_pkg::ADDR_W-1:0] pos_reg;
    logic [efl_pkg::ADDR_W-1:0] pos_next;
    logic [efl_pkg::ID_W-1:0]   res_id_reg;
    logic [efl_pkg::ID_W-1:0]   res_id_next;
    logic                       res_present_reg;
    logic                       res_present_next;
    logic [1:0]                 res_status_reg;
    logic [1:0]                 res_status_next;
    logic [efl_pkg::ID_W-1:0]   out_id_reg;
    logic [efl_pkg::ID_W-1:0]   out_id_next;
    logic                       out_present_reg;
    logic                       out_present_next;
    logic [1:0]                 out_status_reg;
    logic [1:0]                 out_status_next;

    logic                       mem_we;
    logic [efl_pkg::ADDR_W-1:0] mem_waddr;
    logic [efl_pkg::ID_W-1:0]   mem_wdata;
    logic [efl_pkg::ADDR_W-1:0] mem_raddr;
    logic [efl_pkg::ID_W-1:0]   mem_rdata;

    efl_pkg::search_ctl_t       srch_ctl;
    efl_pkg::search_sts_t       srch_sts;
    logic [efl_pkg::ADDR_W-1:0] srch_idx;
    logic [efl_pkg::ID_W-1:0]   srch_target;

    logic [efl_pkg::ADDR_W-1:0] top_addr;
    logic                       id_invalid;

    assign top_addr   = efl_pkg::ADDR_W'(free_count_reg - efl_pkg::CNT_W'(1));
    assign id_invalid = (efl_pkg::CNT_W'(id_reg) >= efl_pkg::MAX_CNT);

    efl_stack_mem u_stack_mem
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    efl_search_unit u_search
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (srch_ctl),
        .target     (srch_target),
        .rd_data    (mem_rdata),
        .free_count (free_count_reg),
        .idx        (srch_idx),
        .sts        (srch_sts)
    );

    always_comb
    begin
        state_next       = state_reg;
        high_mark_next   = high_mark_reg;
        free_count_next  = free_count_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        mode_next        = mode_reg;
        id_next          = id_reg;
        cand_next        = cand_reg;
        pos_next         = pos_reg;
        res_id_next      = res_id_reg;
        res_present_next = res_present_reg;
        res_status_next  = res_status_reg;
        out_id_next      = out_id_reg;
        out_present_next = out_present_reg;
        out_status_next  = out_status_reg;
        mem_we           = 1'b0;
        mem_waddr        = efl_pkg::ADDR_W'(free_count_reg);
        mem_wdata        = id_reg;
        mem_raddr        = srch_idx;
        srch_ctl         = '0;
        srch_target      = id_reg;
        s_tready         = 1'b0;

        unique case (state_reg)
            efl_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    mode_next        = s_tuser;
                    id_next          = s_tdata[efl_pkg::ID_W-1:0];
                    res_id_next      = '0;
                    res_present_next = 1'b0;
                    res_status_next  = efl_pkg::STAT_OK;
                    state_next       = efl_pkg::S_DECODE;
                end
            end

            efl_pkg::S_DECODE:
            begin
                state_next = efl_pkg::S_DONE;
                unique case (mode_reg)
                    efl_pkg::MODE_ALLOC:
                    begin
                        if (free_count_reg != '0)
                        begin
                            mem_raddr  = top_addr;
                            state_next = efl_pkg::S_POP;
                        end
                        else if (high_mark_reg < efl_pkg::MAX_CNT)
                        begin
                            res_id_next    = high_mark_reg[efl_pkg::ID_W-1:0];
                            high_mark_next = high_mark_reg + efl_pkg::CNT_W'(1);
                        end
                        else
                        begin
                            res_status_next = efl_pkg::STAT_FULL;
                        end
                    end

                    efl_pkg::MODE_CLAIM:
                    begin
                        if (id_invalid)
                        begin
                            res_status_next = efl_pkg::STAT_INVALID;
                        end
                        else if (free_count_reg == '0)
                        begin
                            res_status_next = efl_pkg::STAT_NONE;
                        end
                        else
                        begin
                            srch_ctl.start = 1'b1;
                            state_next     = efl_pkg::S_SRD;
                        end
                    end

                    efl_pkg::MODE_RELEASE:
                    begin
                        if (id_invalid)
                        begin
                            res_status_next = efl_pkg::STAT_INVALID;
                        end
                        else if (free_count_reg >= efl_pkg::MAX_CNT)
                        begin
                            res_status_next = efl_pkg::STAT_FULL;
                        end
                        else
                        begin
                            mem_we          = 1'b1;
                            free_count_next = free_count_reg + efl_pkg::CNT_W'(1);
                            res_id_next     = id_reg;
                        end
                    end

                    efl_pkg::MODE_EXISTS:
                    begin
                        if (id_invalid)
                        begin
                            res_status_next = efl_pkg::STAT_INVALID;
                        end
                        else if (efl_pkg::CNT_W'(id_reg) >= high_mark_reg)
                        begin
                            res_present_next = 1'b0;
                        end
                        else if (free_count_reg == '0)
                        begin
                            res_present_next = 1'b1;
                        end
                        else
                        begin
                            srch_ctl.start = 1'b1;
                            state_next     = efl_pkg::S_SRD;
                        end
                    end

                    efl_pkg::MODE_FIRST:
                    begin
                        cand_next  = '0;
                        state_next = efl_pkg::S_CAND;
                    end

                    efl_pkg::MODE_NEXT:
                    begin
                        if (id_invalid)
                        begin
                            res_status_next = efl_pkg::STAT_INVALID;
                        end
                        else
                        begin
                            cand_next  = efl_pkg::CNT_W'(id_reg) + efl_pkg::CNT_W'(1);
                            state_next = efl_pkg::S_CAND;
                        end
                    end

                    default:
                    begin
                        res_status_next = efl_pkg::STAT_INVALID;
                    end
                endcase
            end

            efl_pkg::S_POP:
            begin
                res_id_next     = mem_rdata;
                free_count_next = free_count_reg - efl_pkg::CNT_W'(1);
                state_next      = efl_pkg::S_DONE;
            end

            efl_pkg::S_CAND:
            begin
                srch_target = cand_reg[efl_pkg::ID_W-1:0];
                if (cand_reg >= high_mark_reg)
                begin
                    res_status_next = efl_pkg::STAT_NONE;
                    state_next      = efl_pkg::S_DONE;
                end
                else if (free_count_reg == '0)
                begin
                    res_id_next = cand_reg[efl_pkg::ID_W-1:0];
                    state_next  = efl_pkg::S_DONE;
                end
                else
                begin
                    srch_ctl.start = 1'b1;
                    state_next     = efl_pkg::S_SRD;
                end
            end

            efl_pkg::S_SRD:
            begin
                state_next = efl_pkg::S_SCMP;
            end

            efl_pkg::S_SCMP:
            begin
                if (srch_sts.match)
                begin
                    case (mode_reg)
                        efl_pkg::MODE_CLAIM:
                        begin
                            pos_next   = srch_idx;
                            mem_raddr  = top_addr;
                            state_next = efl_pkg::S_MOVE_WR;
                        end
                        efl_pkg::MODE_EXISTS:
                        begin
                            res_present_next = 1'b0;
                            state_next       = efl_pkg::S_DONE;
                        end
                        default:
                        begin
                            cand_next  = cand_reg + efl_pkg::CNT_W'(1);
                            state_next = efl_pkg::S_CAND;
                        end
                    endcase
                end
                else if (srch_sts.last)
                begin
                    state_next = efl_pkg::S_DONE;
                    case (mode_reg)
                        efl_pkg::MODE_CLAIM:
                        begin
                            res_status_next = efl_pkg::STAT_NONE;
                        end
                        efl_pkg::MODE_EXISTS:
                        begin
                            res_present_next = 1'b1;
                        end
                        default:
                        begin
                            res_id_next = cand_reg[efl_pkg::ID_W-1:0];
                        end
                    endcase
                end
                else
                begin
                    srch_ctl.step = 1'b1;
                    state_next    = efl_pkg::S_SRD;
                end
            end

            efl_pkg::S_MOVE_WR:
            begin
                mem_we          = 1'b1;
                mem_waddr       = pos_reg;
                mem_wdata       = mem_rdata;
                free_count_next = free_count_reg - efl_pkg::CNT_W'(1);
                res_id_next     = id_reg;
                state_next      = efl_pkg::S_DONE;
            end

            efl_pkg::S_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    out_id_next      = (res_status_reg == efl_pkg::STAT_OK) ? res_id_reg : '0;
                    out_present_next = res_present_reg;
                    out_status_next  = res_status_reg;
                    m_valid_next     = 1'b1;
                    state_next       = efl_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = efl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= efl_pkg::S_IDLE;
            high_mark_reg  <= '0;
            free_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            high_mark_reg  <= high_mark_next;
            free_count_reg <= free_count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg        <= mode_next;
        id_reg          <= id_next;
        cand_reg        <= cand_next;
        pos_reg         <= pos_next;
        res_id_reg      <= res_id_next;
        res_present_reg <= res_present_next;
        res_status_reg  <= res_status_next;
        out_id_reg      <= out_id_next;
        out_present_reg <= out_present_next;
        out_status_reg  <= out_status_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, out_present_reg, out_id_reg};
    assign m_tuser  = out_status_reg;

`ifndef NO_ASSERTIONS
    a_free_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_count_reg <= efl_pkg::MAX_CNT)
        else $error("Free stack count exceeds capacity.");

    a_high_mark_bound: assert property (@(posedge clk) disable iff (!rst_n)
        high_mark_reg <= efl_pkg::MAX_CNT)
        else $error("High-water count exceeds capacity.");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("Request accepted while the previous one is still in progress.");

    a_error_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != efl_pkg::STAT_OK) |-> (m_tdata[11:0] == '0))
        else $error("Nonzero identifier returned with an error status.");
`endif

endmodule

>>> hw/rtl/efl_stack_mem.sv
// Free stack storage: one write port and one registered read port.
module efl_stack_mem
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [efl_pkg::ADDR_W-1:0] waddr,
    input  logic [efl_pkg::ID_W-1:0]   wdata,
    input  logic [efl_pkg::ADDR_W-1:0] raddr,
    output logic [efl_pkg::ID_W-1:0]   rdata
);

    logic [efl_pkg::ID_W-1:0] mem [efl_pkg::MAX_ENTITIES];
    logic [efl_pkg::ID_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/efl_search_unit.sv
// Shared search unit: walks the free stack from the bottom and compares each entry to a target.
module efl_search_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  efl_pkg::search_ctl_t        ctl,
    input  logic [efl_pkg::ID_W-1:0]    target,
    input  logic [efl_pkg::ID_W-1:0]    rd_data,
    input  logic [efl_pkg::CNT_W-1:0]   free_count,
    output logic [efl_pkg::ADDR_W-1:0]  idx,
    output efl_pkg::search_sts_t        sts
);

    logic [efl_pkg::ADDR_W-1:0] idx_reg;
    logic [efl_pkg::ADDR_W-1:0] idx_next;
    logic [efl_pkg::ID_W-1:0]   target_reg;

    always_comb
    begin
        idx_next = idx_reg;
        if (ctl.start)
        begin
            idx_next = '0;
        end
        else if (ctl.step)
        begin
            idx_next = idx_reg + efl_pkg::ADDR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            target_reg <= target;
        end
    end

    assign idx       = idx_reg;
    assign sts.match = (rd_data == target_reg);
    assign sts.last  = ((efl_pkg::CNT_W'(idx_reg) + efl_pkg::CNT_W'(1)) >= free_count);

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the free-list identifier allocator, with its own predictor.
module testbench;

    localparam logic [2:0] MODE_UNUSED_6 = 3'd6;
    localparam logic [2:0] MODE_UNUSED_7 = 3'd7;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int POOL_ITEMS = 900;
    localparam int WIDE_ITEMS = 300;
    localparam int POOL_CAP = 40;
    localparam int STACK_SOFT_CAP = 24;
    localparam int TAIL_CYCLES = 24;

    typedef struct {
        logic [11:0]      rid;
        logic             present;
        efl_pkg::status_t st;
    } alloc_result_t;

    typedef struct {
        logic [2:0]    mode;
        logic [11:0]   id;
        bit            typed;
        alloc_result_t want;
    } opening_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic [2:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;

    logic [12:0]   high_mark_m = '0;
    int            free_count_m = 0;
    logic [11:0]   free_stack_m [efl_pkg::MAX_ENTITIES];
    alloc_result_t pending_results [$];
    alloc_result_t blank_result;
    int            mismatches = 0;
    int            requests_sent = 0;
    int            results_seen = 0;
    int            idle_cycles = 0;
    int            send_run = 0;
    int            recv_run = 0;

    // Rows with a typed result can be read straight off the reset state.
    opening_row_t opening_rows [25] = '{
        '{efl_pkg::MODE_FIRST,   12'd0,    1'b1, '{12'd0, 1'b0, efl_pkg::STAT_NONE}},
        '{efl_pkg::MODE_NEXT,    12'd4095, 1'b1, '{12'd0, 1'b0, efl_pkg::STAT_NONE}},
        '{efl_pkg::MODE_EXISTS,  12'd0,    1'b1, '{12'd0, 1'b0, efl_pkg::STAT_OK}},
        '{efl_pkg::MODE_CLAIM,   12'd5,    1'b1, '{12'd0, 1'b0, efl_pkg::STAT_NONE}},
        '{MODE_UNUSED_6,         12'd4095, 1'b1, '{12'd0, 1'b0, efl_pkg::STAT_INVALID}},
        '{MODE_UNUSED_7,         12'd0,    1'b1, '{12'd0, 1'b0, efl_pkg::STAT_INVALID}},
        '{efl_pkg::MODE_ALLOC,   12'd4095, 1'b1, '{12'd0, 1'b0, efl_pkg::STAT_OK}},
        '{efl_pkg::MODE_ALLOC,   12'd0,    1'b1, '{12'd1, 1'b0, efl_pkg::STAT_OK}},
        '{efl_pkg::MODE_ALLOC,   12'd0,    1'b1, '{12'd2, 1'b0, efl_pkg::STAT_OK}},
        '{efl_pkg::MODE_ALLOC,   12'd0,    1'b1, '{12'd3, 1'b0, efl_pkg::STAT_OK}},
        '{efl_pkg::MODE_EXISTS,  12'd3,    1'b1, '{12'd0, 1'b1, efl_pkg::STAT_OK}},
        '{efl_pkg::MODE_EXISTS,  12'd4,    1'b1, '{12'd0, 1'b0, efl_pkg::STAT_OK}},
        '{efl_pkg::MODE_RELEASE, 12'd1,    1'b1, '{12'd1, 1'b0, efl_pkg::STAT_OK}},
        '{efl_pkg::MODE_RELEASE, 12'd3,    1'b1, '{12'd3, 1'b0, efl_pkg::STAT_OK}},
        '{efl_pkg::MODE_EXISTS,  12'd1,    1'b0, '{12'd0, 1'b0, efl_pkg::STAT_OK}},
        '{efl_pkg::MODE_FIRST,   12'd0,    1'b0, '{12'd0, 1'b0, efl_pkg::STAT_OK}},
        '{efl_pkg::MODE_NEXT,    12'd0,    1'b0, '{12'd0, 1'b0, efl_pkg::STAT_OK}},
        '{efl_pkg::MODE_NEXT,    12'd2,    1'b0, '{12'd0, 1'b0, efl_pkg::STAT_OK}},
        '{efl_pkg::MODE_CLAIM,   12'd1,    1'b0, '{12'd0, 1'b0, efl_pkg::STAT_OK}},
        '{efl_pkg::MODE_CLAIM,   12'd1,    1'b0, '{12'd0, 1'b0, efl_pkg::STAT_OK}},
        '{efl_pkg::MODE_RELEASE, 12'd3,    1'b0, '{12'd0, 1'b0, efl_pkg::STAT_OK}},
        '{efl_pkg::MODE_ALLOC,   12'd0,    1'b0, '{12'd0, 1'b0, efl_pkg::STAT_OK}},
        '{efl_pkg::MODE_ALLOC,   12'd0,    1'b0, '{12'd0, 1'b0, efl_pkg::STAT_OK}},
        '{efl_pkg::MODE_RELEASE, 12'd4095, 1'b0, '{12'd0, 1'b0, efl_pkg::STAT_OK}},
        '{efl_pkg::MODE_ALLOC,   12'd0,    1'b0, '{12'd0, 1'b0, efl_pkg::STAT_OK}}
    };

    entity_id_free_list_allocator dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #4 clk = ~clk;

    function automatic int draw_gap(inout int run_left);
        if (run_left > 0)
        begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 29) == 0)
            run_left = $urandom_range(8, 40);
        return $urandom_range(0, 16);
    endfunction

    function automatic int stack_position(logic [11:0] id);
        for (int i = 0; i < free_count_m; i++)
        begin
            if (free_stack_m[i] == id)
                return i;
        end
        return -1;
    endfunction

    function automatic bit lowest_live(int start, output logic [11:0] found);
        found = '0;
        for (int i = start; i < int'(high_mark_m); i++)
        begin
            if (stack_position(12'(i)) < 0)
            begin
                found = 12'(i);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic alloc_result_t predict_allocation(logic [2:0] mode, logic [11:0] id);
        alloc_result_t r;
        int            pos;
        bit            id_ok;
        r.rid = '0;
        r.present = 1'b0;
        r.st = efl_pkg::STAT_OK;
        id_ok = id < efl_pkg::MAX_ENTITIES;
        case (mode)
            efl_pkg::MODE_ALLOC:
            begin
                if (free_count_m > 0)
                begin
                    free_count_m--;
                    r.rid = free_stack_m[free_count_m];
                end
                else if (high_mark_m < efl_pkg::MAX_ENTITIES)
                begin
                    r.rid = high_mark_m[11:0];
                    high_mark_m++;
                end
                else
                    r.st = efl_pkg::STAT_FULL;
            end
            efl_pkg::MODE_CLAIM:
            begin
                pos = stack_position(id);
                if (!id_ok)
                    r.st = efl_pkg::STAT_INVALID;
                else if (pos < 0)
                    r.st = efl_pkg::STAT_NONE;
                else
                begin
                    free_count_m--;
                    free_stack_m[pos] = free_stack_m[free_count_m];
                    r.rid = id;
                end
            end
            efl_pkg::MODE_RELEASE:
            begin
                if (!id_ok)
                    r.st = efl_pkg::STAT_INVALID;
                else if (free_count_m >= efl_pkg::MAX_ENTITIES)
                    r.st = efl_pkg::STAT_FULL;
                else
                begin
                    free_stack_m[free_count_m] = id;
                    free_count_m++;
                    r.rid = id;
                end
            end
            efl_pkg::MODE_EXISTS:
            begin
                if (!id_ok)
                    r.st = efl_pkg::STAT_INVALID;
                else
                    r.present = (id < high_mark_m) && (stack_position(id) < 0);
            end
            efl_pkg::MODE_FIRST:
            begin
                if (!lowest_live(0, r.rid))
                    r.st = efl_pkg::STAT_NONE;
            end
            efl_pkg::MODE_NEXT:
            begin
                if (!id_ok)
                    r.st = efl_pkg::STAT_INVALID;
                else if (!lowest_live(int'(id) + 1, r.rid))
                    r.st = efl_pkg::STAT_NONE;
            end
            default:
                r.st = efl_pkg::STAT_INVALID;
        endcase
        if (r.st != efl_pkg::STAT_OK)
            r.rid = '0;
        return r;
    endfunction

    function automatic logic [11:0] near_id();
        int top;
        top = int'(high_mark_m) + 1;
        if (top > efl_pkg::MAX_ENTITIES - 1)
            top = efl_pkg::MAX_ENTITIES - 1;
        return 12'($urandom_range(0, top));
    endfunction

    task automatic issue_request(logic [2:0] mode, logic [11:0] id, bit typed,
                                 alloc_result_t want);
        int            gap;
        alloc_result_t predicted;
        gap = draw_gap(send_run);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {4'b0000, id};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = predict_allocation(mode, id);
        if (typed)
            pending_results.push_back(want);
        else
            pending_results.push_back(predicted);
        requests_sent++;
    endtask

    task automatic settle_outstanding();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Mostly well-formed traffic on a pool bounded by pool_cap; the free stack is kept short so that
    // scans stay quick.
    task automatic random_request(int pool_cap);
        logic [2:0]  mode;
        logic [11:0] id;
        int          pick;
        pick = $urandom_range(0, 99);
        id = 12'($urandom);
        if (free_count_m > STACK_SOFT_CAP)
            mode = efl_pkg::MODE_ALLOC;
        else if (pick < 22)
        begin
            mode = efl_pkg::MODE_ALLOC;
            if (free_count_m == 0 && high_mark_m >= pool_cap)
            begin
                mode = efl_pkg::MODE_RELEASE;
                id = 12'($urandom_range(0, int'(high_mark_m) - 1));
            end
        end
        else if (pick < 36)
        begin
            mode = efl_pkg::MODE_CLAIM;
            if (free_count_m > 0 && $urandom_range(0, 3) != 0)
                id = free_stack_m[$urandom_range(0, free_count_m - 1)];
            else if ($urandom_range(0, 1) == 1)
                id = near_id();
        end
        else if (pick < 54)
        begin
            mode = efl_pkg::MODE_RELEASE;
            if (high_mark_m > 0 && $urandom_range(0, 4) != 0)
                id = 12'($urandom_range(0, int'(high_mark_m) - 1));
        end
        else if (pick < 70)
        begin
            mode = efl_pkg::MODE_EXISTS;
            if ($urandom_range(0, 3) != 0)
                id = near_id();
        end
        else if (pick < 80)
            mode = efl_pkg::MODE_FIRST;
        else if (pick < 94)
        begin
            mode = efl_pkg::MODE_NEXT;
            if ($urandom_range(0, 3) != 0)
                id = near_id();
        end
        else
            mode = ($urandom_range(0, 1) == 1) ? MODE_UNUSED_6 : MODE_UNUSED_7;
        issue_request(mode, id, 1'b0, blank_result);
    endtask

    initial
    begin
        alloc_result_t want;
        int            gap;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = draw_gap(recv_run);
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result word with none expected: result_id %0d, status %0d",
                       m_tdata[11:0], m_tuser);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[11:0] !== want.rid)
                begin
                    $error("result_id: expected %0d, actual %0d", want.rid, m_tdata[11:0]);
                    mismatches++;
                end
                if (m_tdata[12] !== want.present)
                begin
                    $error("present: expected %0d, actual %0d", want.present, m_tdata[12]);
                    mismatches++;
                end
                if (m_tuser !== want.st)
                begin
                    $error("status: expected %0d, actual %0d", want.st, m_tuser);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_rows[i])
            issue_request(opening_rows[i].mode, opening_rows[i].id, opening_rows[i].typed,
                          opening_rows[i].want);
        settle_outstanding();

        for (int n = 0; n < POOL_ITEMS; n++)
        begin
            if ($urandom_range(0, 59) == 0)
                settle_outstanding();
            random_request(POOL_CAP);
        end
        settle_outstanding();

        for (int n = 0; n < WIDE_ITEMS; n++)
        begin
            if ($urandom_range(0, 59) == 0)
                settle_outstanding();
            random_request(efl_pkg::MAX_ENTITIES + 1);
        end
        settle_outstanding();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Checked %0d requests and %0d result words across all six modes and both",
                 requests_sent, results_seen);
        $display("undefined modes, on a small recycled pool and on the open identifier range.");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/efl_pkg.sv
hw/rtl/efl_stack_mem.sv
hw/rtl/efl_search_unit.sv
hw/rtl/entity_id_free_list_allocator.sv
bench/testbench.sv
